// File: rtl/core/chkv_pkg.sv
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared types and constants of the chained hash key/value table.
// ----------------------------------------------------------------------------
package chkv_pkg;

    localparam int NUM_BUCKETS_DEF = 1024;
    localparam int NUM_ENTRIES_DEF = 256;
    localparam int KEY_BITS_DEF    = 32;
    localparam int DATA_BITS_DEF   = 32;

    localparam int MIN_BUCKETS = 5;
    localparam int BC_CFG_W    = 11;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 4;

    localparam logic [1:0] REG_BUCKET_COUNT = 2'd0;
    localparam logic [1:0] REG_INVALID_KEY  = 2'd1;
    localparam logic [1:0] REG_RELEASE_EN   = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic div;
        logic head_rd;
        logic cur_init;
        logic ent_rd;
        logic cmp;
        logic act;
        logic alloc;
        logic emit;
    } chkv_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic skip;
        logic div_done;
        logic walk_end;
        logic key_match;
        logic need_alloc;
        logic out_free;
    } chkv_sts_t;

endpackage

// File: rtl/core/chkv_ctrl.sv
// ----------------------------------------------------------------------------
// chkv_ctrl
// Sequencer: clearing pass, remainder, chain walk, update and result.
// ----------------------------------------------------------------------------
module chkv_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  chkv_pkg::chkv_sts_t sts,
    output chkv_pkg::chkv_cmd_t cmd
);
    import chkv_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_HEAD, S_HLOAD, S_LOOK, S_CMP, S_ACT, S_ALLOC, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.skip) begin
                    state_next = S_EMIT;
                end else if (sts.div_done) begin
                    state_next = S_HEAD;
                end else begin
                    cmd.div = 1'b1;
                end
            end
            S_HEAD: begin
                cmd.head_rd = 1'b1;
                state_next  = S_HLOAD;
            end
            S_HLOAD: begin
                cmd.cur_init = 1'b1;
                state_next   = S_LOOK;
            end
            S_LOOK: begin
                if (sts.walk_end) begin
                    state_next = S_ACT;
                end else begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = sts.key_match ? S_ACT : S_LOOK;
            end
            S_ACT: begin
                cmd.act    = 1'b1;
                state_next = sts.need_alloc ? S_ALLOC : S_EMIT;
            end
            S_ALLOC: begin
                cmd.alloc  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

endmodule

// File: rtl/core/chkv_dp.sv
// ----------------------------------------------------------------------------
// chkv_dp
// Datapath: bucket heads, entry pool, free stack, remainder unit, result.
// ----------------------------------------------------------------------------
module chkv_dp #(
    parameter int NUM_BUCKETS = chkv_pkg::NUM_BUCKETS_DEF,
    parameter int NUM_ENTRIES = chkv_pkg::NUM_ENTRIES_DEF,
    parameter int KEY_BITS    = chkv_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS   = chkv_pkg::DATA_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  chkv_pkg::chkv_cmd_t           cmd,
    output chkv_pkg::chkv_sts_t           sts,
    input  logic [1:0]                    in_op,
    input  logic [KEY_BITS-1:0]           in_key,
    input  logic [DATA_BITS-1:0]          in_data,
    input  logic [chkv_pkg::BC_CFG_W-1:0] bucket_count,
    input  logic [chkv_pkg::CFG_DATA_W-1:0] reject_key,
    input  logic                          release_enable,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_found,
    output logic [DATA_BITS-1:0]          m_data_out,
    output logic                          m_released
);
    import chkv_pkg::*;

    localparam int EW    = $clog2(NUM_ENTRIES);
    localparam int PW    = EW + 1;
    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int BCW   = $clog2(NUM_BUCKETS + 1);
    localparam int CW    = (BCW > BC_CFG_W) ? BCW : BC_CFG_W;
    localparam int DCW   = $clog2(KEY_BITS + 1);
    localparam int CLR_N = (NUM_BUCKETS > NUM_ENTRIES) ? NUM_BUCKETS : NUM_ENTRIES;
    localparam int CLRW  = $clog2(CLR_N);
    localparam logic [PW-1:0] NONE = PW'(NUM_ENTRIES);

    logic [PW-1:0]        head_mem  [NUM_BUCKETS];
    logic [KEY_BITS-1:0]  key_mem   [NUM_ENTRIES];
    logic [DATA_BITS-1:0] data_mem  [NUM_ENTRIES];
    logic [PW-1:0]        link_mem  [NUM_ENTRIES];
    logic [EW-1:0]        stack_mem [NUM_ENTRIES];

    logic [CLRW-1:0]      clr_cnt_reg;
    logic [PW-1:0]        free_top_reg;
    op_t                  op_reg;
    logic [KEY_BITS-1:0]  key_reg, kshift_reg, key_q;
    logic [DATA_BITS-1:0] data_reg, data_q;
    logic [BCW-1:0]       rem_reg;
    logic [DCW-1:0]       div_cnt_reg;
    logic [PW-1:0]        head_q, link_q, cur_reg, prev_reg, steps_reg;
    logic [EW-1:0]        pop_q;
    logic                 found_reg, full_reg, rel_reg;
    logic [DATA_BITS-1:0] dout_reg;

    logic [CW-1:0]        bc_ext;
    logic [BCW-1:0]       div_d;
    logic [BCW:0]         shifted;
    logic [BW-1:0]        bidx;
    logic [EW-1:0]        cur_idx, prev_idx, top_idx, top_m1;
    logic                 key_invalid, clr_head, clr_stack;
    logic                 del_hit, ins_hit, ins_new;

    always_comb begin
        bc_ext = CW'(bucket_count);
        if (bc_ext < CW'(MIN_BUCKETS)) begin
            div_d = BCW'(MIN_BUCKETS);
        end else if (bc_ext > CW'(NUM_BUCKETS)) begin
            div_d = BCW'(NUM_BUCKETS);
        end else begin
            div_d = BCW'(bc_ext);
        end
    end

    assign shifted     = {rem_reg, kshift_reg[KEY_BITS-1]};
    assign bidx        = rem_reg[BW-1:0];
    assign cur_idx     = cur_reg[EW-1:0];
    assign prev_idx    = prev_reg[EW-1:0];
    assign top_idx     = free_top_reg[EW-1:0];
    assign top_m1      = EW'(free_top_reg - PW'(1));
    assign key_invalid = (key_reg == KEY_BITS'(reject_key));
    assign clr_head    = cmd.clr && ({1'b0, clr_cnt_reg} < (CLRW + 1)'(NUM_BUCKETS));
    assign clr_stack   = cmd.clr && ({1'b0, clr_cnt_reg} < (CLRW + 1)'(NUM_ENTRIES));
    assign del_hit     = cmd.act && (op_reg == OP_DELETE) && found_reg;
    assign ins_hit     = cmd.act && (op_reg == OP_INSERT) && found_reg;
    assign ins_new     = (op_reg == OP_INSERT) && !found_reg;

    assign sts.clr_done   = (clr_cnt_reg == CLRW'(CLR_N - 1));
    assign sts.skip       = (op_reg == OP_NONE) || key_invalid;
    assign sts.div_done   = (div_cnt_reg == DCW'(KEY_BITS));
    assign sts.walk_end   = (cur_reg >= NONE) || (steps_reg == NONE);
    assign sts.key_match  = (key_q == key_reg);
    assign sts.need_alloc = ins_new && (free_top_reg != '0);
    assign sts.out_free   = !m_valid || m_ready;

    // memories
    always_ff @(posedge aclk) begin
        if (clr_head) begin
            head_mem[clr_cnt_reg[BW-1:0]] <= NONE;
        end else if (cmd.alloc) begin
            head_mem[bidx] <= PW'(pop_q);
        end else if (del_hit && (prev_reg == NONE)) begin
            head_mem[bidx] <= link_q;
        end
        if (cmd.head_rd) head_q <= head_mem[bidx];
    end

    always_ff @(posedge aclk) begin
        if (clr_stack) begin
            stack_mem[clr_cnt_reg[EW-1:0]] <= clr_cnt_reg[EW-1:0];
        end else if (del_hit && (free_top_reg < NONE)) begin
            stack_mem[top_idx] <= cur_idx;
        end
        if (cmd.act) pop_q <= stack_mem[top_m1];
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            key_mem[pop_q] <= key_reg;
        end
        if (cmd.ent_rd) key_q <= key_mem[cur_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            data_mem[pop_q] <= data_reg;
        end else if (ins_hit) begin
            data_mem[cur_idx] <= data_reg;
        end
        if (cmd.ent_rd) data_q <= data_mem[cur_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            link_mem[pop_q] <= head_q;
        end else if (del_hit && (prev_reg != NONE)) begin
            link_mem[prev_idx] <= link_q;
        end
        if (cmd.ent_rd) link_q <= link_mem[cur_idx];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            free_top_reg <= NONE;
            m_valid      <= 1'b0;
        end else begin
            if (cmd.clr && !sts.clr_done) clr_cnt_reg <= clr_cnt_reg + CLRW'(1);
            if (cmd.act && sts.need_alloc) begin
                free_top_reg <= free_top_reg - PW'(1);
            end else if (del_hit && (free_top_reg < NONE)) begin
                free_top_reg <= free_top_reg + PW'(1);
            end
            if (cmd.emit) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // request and walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= op_t'(in_op);
            key_reg     <= in_key;
            kshift_reg  <= in_key;
            data_reg    <= in_data;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            found_reg   <= 1'b0;
            full_reg    <= 1'b0;
            rel_reg     <= 1'b0;
            dout_reg    <= '0;
        end
        if (cmd.div) begin
            if (shifted >= {1'b0, div_d}) begin
                rem_reg <= BCW'(shifted - {1'b0, div_d});
            end else begin
                rem_reg <= BCW'(shifted);
            end
            kshift_reg  <= kshift_reg << 1;
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
        if (cmd.cur_init) begin
            cur_reg   <= head_q;
            prev_reg  <= NONE;
            steps_reg <= '0;
        end
        if (cmd.cmp) begin
            if (sts.key_match) begin
                found_reg <= 1'b1;
            end else begin
                prev_reg  <= cur_reg;
                cur_reg   <= link_q;
                steps_reg <= steps_reg + PW'(1);
            end
        end
        if (cmd.act) begin
            if (found_reg && (op_reg == OP_GET)) begin
                dout_reg <= data_q;
            end else if (found_reg && (op_reg != OP_GET) && release_enable) begin
                dout_reg <= data_q;
                rel_reg  <= 1'b1;
            end
            if (ins_new && (free_top_reg == '0)) full_reg <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if ((op_reg != OP_NONE) && key_invalid) begin
                m_status <= ST_INVALID;
            end else if (full_reg) begin
                m_status <= ST_FULL;
            end else begin
                m_status <= ST_OK;
            end
            m_found    <= found_reg;
            m_data_out <= dout_reg;
            m_released <= rel_reg;
        end
    end

endmodule

// File: rtl/core/chained_hash_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_key_value_table_unit
// Key-to-data map with separate chaining over a bounded entry pool.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the unit runs a clearing pass
// that empties the bucket heads and fills the free stack; no request is taken
// during it. A request then runs through the remainder, the chain walk, the
// update and the result: the bucket remainder comes from a restoring divider
// that retires one key bit per cycle, and each chain step is one registered
// read of the entry memories followed by a key compare. When an insert finds
// no match and the pool is not empty, a new entry is taken from the pool.
// Invalid keys and the unused operation code skip the walk. A finished result
// waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module chained_hash_key_value_table_unit #(
    parameter int NUM_BUCKETS = chkv_pkg::NUM_BUCKETS_DEF,
    parameter int NUM_ENTRIES = chkv_pkg::NUM_ENTRIES_DEF,
    parameter int KEY_BITS    = chkv_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS   = chkv_pkg::DATA_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [chkv_pkg::CFG_ADDR_W-1:0]             paddr,
    input  logic [chkv_pkg::CFG_DATA_W-1:0]             pwdata,
    output logic [chkv_pkg::CFG_DATA_W-1:0]             prdata,
    output logic                                        pready,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // key, data
    input  logic [((KEY_BITS+DATA_BITS+7)/8)*8-1:0]     s_tdata,
    // operation
    input  logic [1:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // status, found, data_out, released
    output logic [((DATA_BITS+4+7)/8)*8-1:0]            m_tdata
);
    import chkv_pkg::*;

    localparam int OUT_W   = ((DATA_BITS + 4 + 7) / 8) * 8;
    localparam int REL_BIT = DATA_BITS + 3;

    logic [BC_CFG_W-1:0]   bucket_count_reg;
    logic [CFG_DATA_W-1:0] reject_key_reg;
    logic                  release_enable_reg;
    logic [1:0]            reg_idx;
    logic                  cfg_wr;

    chkv_cmd_t             cmd;
    chkv_sts_t             sts;
    logic [1:0]            m_status;
    logic                  m_found, m_released;
    logic [DATA_BITS-1:0]  m_data_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg   <= BC_CFG_W'(MIN_BUCKETS);
            reject_key_reg     <= '1;
            release_enable_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BUCKET_COUNT: bucket_count_reg   <= pwdata[BC_CFG_W-1:0];
                REG_INVALID_KEY:  reject_key_reg     <= pwdata;
                REG_RELEASE_EN:   release_enable_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BUCKET_COUNT: prdata = CFG_DATA_W'(bucket_count_reg);
            REG_INVALID_KEY:  prdata = reject_key_reg;
            REG_RELEASE_EN:   prdata = CFG_DATA_W'(release_enable_reg);
            default:          prdata = '0;
        endcase
    end

    chkv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    chkv_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .NUM_ENTRIES (NUM_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_op          (s_tuser),
        .in_key         (s_tdata[KEY_BITS-1:0]),
        .in_data        (s_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS]),
        .bucket_count   (bucket_count_reg),
        .reject_key     (reject_key_reg),
        .release_enable (release_enable_reg),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_status       (m_status),
        .m_found        (m_found),
        .m_data_out     (m_data_out),
        .m_released     (m_released)
    );

    assign m_tdata = OUT_W'({m_released, m_data_out, m_found, m_status});

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    a_release_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[REL_BIT]) |-> m_tdata[2])
        else $error("release without a found entry");

    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == ST_INVALID)) |-> (!m_tdata[2] && !m_tdata[REL_BIT]))
        else $error("invalid key result carries flags");

    a_full_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == ST_FULL)) |-> !m_tdata[2])
        else $error("full status on a present key");

endmodule

// File: tb/chkv_scoreboard.sv
// ----------------------------------------------------------------------------
// chkv_scoreboard
// Watches the request, reply and register ports of the chained hash table,
// keeps a shadow copy of the chains, the entry pool and the registers, and
// compares every reply field by field with the predicted one.
// ----------------------------------------------------------------------------
module chkv_scoreboard
    import chkv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [63:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = NUM_BUCKETS_DEF;
    localparam int NE = NUM_ENTRIES_DEF;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [31:0] data_out;
        logic        released;
    } reply_t;

    logic [8:0]  head_of[NB];
    logic [31:0] key_of[NE];
    logic [31:0] data_of[NE];
    logic [8:0]  link_of[NE];
    logic [7:0]  free_list[NE];
    logic [8:0]  free_cnt;

    logic [10:0] bucket_reg;
    logic [31:0] bad_key;
    logic        rel_en;

    reply_t pending_replies[$];

    function automatic reply_t lookup_and_update(op_t op, logic [31:0] key,
                                                 logic [31:0] data);
        reply_t r;
        int unsigned nb;
        int unsigned b;
        logic [8:0] cur;
        logic [8:0] prev;
        logic [8:0] hit;
        logic [8:0] e;
        r = '{status: ST_OK, found: 1'b0, data_out: '0, released: 1'b0};
        if (op == OP_NONE) return r;
        if (key == bad_key) begin
            r.status = ST_INVALID;
            return r;
        end
        nb = bucket_reg;
        if (nb < MIN_BUCKETS) nb = MIN_BUCKETS;
        if (nb > NB) nb = NB;
        b = key % nb;
        cur = head_of[b];
        prev = 9'(NE);
        hit = 9'(NE);
        for (int s = 0; s < NE && cur < NE; s++) begin
            if (key_of[cur] == key) begin
                hit = cur;
                break;
            end
            prev = cur;
            cur = link_of[cur];
        end
        r.found = (hit < NE);
        case (op)
            OP_INSERT: begin
                if (r.found) begin
                    if (rel_en) begin
                        r.data_out = data_of[hit];
                        r.released = 1'b1;
                    end
                    data_of[hit] = data;
                end else if (free_cnt == 0) begin
                    r.status = ST_FULL;
                end else begin
                    free_cnt--;
                    e = free_list[free_cnt];
                    key_of[e] = key;
                    data_of[e] = data;
                    link_of[e] = head_of[b];
                    head_of[b] = e;
                end
            end
            OP_DELETE: begin
                if (r.found) begin
                    if (prev < NE) link_of[prev] = link_of[hit];
                    else head_of[b] = link_of[hit];
                    if (rel_en) begin
                        r.data_out = data_of[hit];
                        r.released = 1'b1;
                    end
                    free_list[free_cnt] = hit[7:0];
                    free_cnt++;
                end
            end
            default: begin
                if (r.found) r.data_out = data_of[hit];
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        int     bad;
        bad = 0;
        if (!aresetn) begin
            for (int i = 0; i < NB; i++) head_of[i] = 9'(NE);
            for (int i = 0; i < NE; i++) begin
                free_list[i] = 8'(i);
                key_of[i] = '0;
                data_of[i] = '0;
                link_of[i] = 9'(NE);
            end
            free_cnt = 9'(NE);
            bucket_reg = 11'(MIN_BUCKETS);
            bad_key = 32'hFFFF_FFFF;
            rel_en = 1'b0;
            errors <= 0;
            pending_replies.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_BUCKET_COUNT: bucket_reg = pwdata[10:0];
                    REG_INVALID_KEY:  bad_key = pwdata;
                    REG_RELEASE_EN:   rel_en = pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(lookup_and_update(op_t'(s_tuser),
                                          s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready) begin
                got = '{status: status_t'(m_tdata[1:0]), found: m_tdata[2],
                        data_out: m_tdata[34:3], released: m_tdata[35]};
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected reply %h", $time, m_tdata);
                    bad++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, got.status);
                        bad++;
                    end
                    if (got.found !== want.found) begin
                        $display("%0t: found expected %0d got %0d", $time,
                                 want.found, got.found);
                        bad++;
                    end
                    if (got.data_out !== want.data_out) begin
                        $display("%0t: data_out expected %h got %h", $time,
                                 want.data_out, got.data_out);
                        bad++;
                    end
                    if (got.released !== want.released) begin
                        $display("%0t: released expected %0d got %0d", $time,
                                 want.released, got.released);
                        bad++;
                    end
                    if (m_tdata[39:36] !== 4'd0) begin
                        $display("%0t: pad bits expected 0 got %h", $time,
                                 m_tdata[39:36]);
                        bad++;
                    end
                end
            end
            errors <= errors + bad;
        end
        pending <= pending_replies.size();
    end
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete and get requests into the chained hash table under
// several register settings: directed corner requests, a pool fill past
// capacity, then random traffic over a small key set, with random gaps and
// back-pressure on both streams. The scoreboard judges every reply.
// ----------------------------------------------------------------------------
module testbench;
    import chkv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;

    int          errors;
    int          pending;
    bit          no_gaps = 1'b0;
    bit          hold_off = 1'b0;
    logic [31:0] bad_key = 32'hFFFF_FFFF;
    logic [31:0] key_set[48];

    chained_hash_key_value_table_unit DUT (.*);

    chkv_scoreboard checker_i (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // reply side back-pressure
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send(op_t op, logic [31:0] key, logic [31:0] data);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {data, key};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        if (idx == REG_INVALID_KEY) bad_key = value;
    endtask

    task automatic set_regs(logic [31:0] bc, logic [31:0] ik, logic [31:0] re);
        drain();
        write_reg(REG_BUCKET_COUNT, bc);
        write_reg(REG_INVALID_KEY, ik);
        write_reg(REG_RELEASE_EN, re);
    endtask

    task automatic random_traffic(int count);
        int          pick;
        logic [31:0] key;
        op_t         op;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 80) key = key_set[$urandom_range(0, 47)];
            else if (pick < 85) key = bad_key;
            else key = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 40) op = OP_INSERT;
            else if (pick < 65) op = OP_DELETE;
            else if (pick < 97) op = OP_GET;
            else op = OP_NONE;
            send(op, key, $urandom);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < 48; i++)
            key_set[i] = (i < 24) ? i * 5 + $urandom_range(0, 1) : $urandom;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners under reset register values
        send(OP_GET, 32'd0, 32'd0);
        send(OP_INSERT, 32'd0, 32'd0);
        send(OP_INSERT, 32'd0, 32'hFFFF_FFFF);
        send(OP_GET, 32'd0, 32'd0);
        send(OP_INSERT, 32'hFFFF_FFFE, 32'hA5A5_5A5A);
        send(OP_INSERT, 32'd5, 32'd1);
        send(OP_INSERT, 32'd10, 32'd2);
        send(OP_INSERT, 32'd15, 32'd3);
        send(OP_DELETE, 32'd10, 32'd0);
        send(OP_GET, 32'd15, 32'd0);
        send(OP_GET, 32'd10, 32'd0);
        send(OP_DELETE, 32'd10, 32'd0);
        send(OP_INSERT, 32'hFFFF_FFFF, 32'd7);
        send(OP_DELETE, 32'hFFFF_FFFF, 32'd7);
        send(OP_GET, 32'hFFFF_FFFF, 32'd7);
        send(OP_NONE, 32'd5, 32'hFFFF_FFFF);
        send(OP_GET, 32'd5, 32'd0);

        // bucket count below minimum, release on, key zero invalid
        set_regs(32'd3, 32'd0, 32'd1);
        send(OP_GET, 32'd0, 32'd0);
        send(OP_INSERT, 32'd5, 32'd9);
        send(OP_DELETE, 32'd15, 32'd0);
        send(OP_GET, 32'hFFFF_FFFE, 32'd0);
        hold_off = 1'b1;
        random_traffic(120);

        // bucket count above maximum, entries placed earlier become stale
        set_regs(32'd2047, 32'hFFFF_FFFF, 32'd1);
        for (int i = 0; i < 262; i++) send(OP_INSERT, i * 3 + 100, $urandom);
        send(OP_GET, 32'd100, 32'd0);
        for (int i = 0; i < 262; i++) send(OP_DELETE, i * 3 + 100, 32'd0);

        set_regs(32'd1024, 32'h8000_0000, 32'd0);
        random_traffic(100);

        set_regs(32'd7, $urandom, 32'd1);
        random_traffic(100);

        set_regs(32'd0, key_set[3], 32'd0);
        random_traffic(80);

        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
